### rtl/core/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque check failed");

// next-cycle implication, disabled while reset is held
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque check failed");

`endif

### rtl/core/deq_pkg.sv
// shared types and codes for the double-ended queue
package deq_pkg;

    localparam int OP_W   = 3;
    localparam int VAL_W  = 32;
    localparam int POS_W  = 8;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 7;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_INDEX      = 3'd4;
    localparam logic [OP_W-1:0] OP_RANGE      = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic capture;
        logic exec;
        logic range_step;
    } t_dp_cmd;

    typedef struct packed {
        logic range_go;
        logic range_done;
    } t_dp_status;

endpackage

### rtl/core/double_ended_queue.sv
// top level of the bounded double-ended queue
//
// command channel: an operation is taken at a rising edge with start high
// and busy low; operation, item_value, position and range_stop are sampled
// in that same edge.
// result channel: each result sits on the o_ ports for one cycle with
// o_strobe high; the receiver cannot hold it off, so no stall exists.
// push front/back, pop front/back and index each give one result beat with
// o_last set. o_strobe rises as the sequencer leaves the execute state,
// and busy drops together with it, so a new command is taken only once
// the previous result is out. a range of n elements gives n beats on
// consecutive cycles, the last one flagged; the first beat follows the
// execute state and the first range step; busy holds through execute
// and the whole range walk. an empty or out-of-bounds range gives a
// single status beat like the other operations. the execute state does
// decode and position arithmetic, and the registered ring read of single ops.
// reset (synchronous, active low) empties the queue: front pointer and
// count go to zero, the sequencer idles and no strobe is shown. slot
// contents are not cleared; only stored entries are ever read.
module double_ended_queue #(
    parameter int DEPTH       = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic        [deq_pkg::OP_W-1:0]     i_operation,
    input  logic        [deq_pkg::VAL_W-1:0]    i_item_value,
    input  logic signed [deq_pkg::POS_W-1:0]    i_position,
    input  logic signed [deq_pkg::POS_W-1:0]    i_range_stop,
    output logic                                o_strobe,
    output logic        [deq_pkg::VAL_W-1:0]    o_result_value,
    output logic        [deq_pkg::STAT_W-1:0]   o_status,
    output logic        [deq_pkg::CNT_W-1:0]    o_stored_count,
    output logic        [deq_pkg::CNT_W-1:0]    o_range_count,
    output logic                                o_last
);
    import deq_pkg::*;

    // commands from the sequencer, status back from the datapath
    t_dp_cmd    w_cmd;
    t_dp_status w_dp_status;

    // sequencer: idle -> execute -> (range walk) -> idle
    deq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .o_cmd    (w_cmd),
        .i_status (w_dp_status)
    );

    // ring memory, pointers and result registers
    deq_dpath #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status_ctl   (w_dp_status),
        .i_operation    (i_operation),
        .i_item_value   (i_item_value),
        .i_position     (i_position),
        .i_range_stop   (i_range_stop),
        .o_strobe       (o_strobe),
        .o_result_value (o_result_value),
        .o_status       (o_status),
        .o_stored_count (o_stored_count),
        .o_range_count  (o_range_count),
        .o_last         (o_last)
    );

endmodule

### rtl/core/deq_ctrl.sv
// sequencer for the double-ended queue: idle, execute, range walk
module deq_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    output deq_pkg::t_dp_cmd    o_cmd,
    input  deq_pkg::t_dp_status i_status
);
    import deq_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_RANGE = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state          = r_state;
        o_cmd.capture    = 1'b0;
        o_cmd.exec       = 1'b0;
        o_cmd.range_step = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_status.range_go ? S_RANGE : S_IDLE;
            end
            S_RANGE: begin
                o_cmd.range_step = 1'b1;
                if (i_status.range_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

### rtl/core/deq_dpath.sv
// ring storage, pointers, position arithmetic and result registers
module deq_dpath #(
    parameter int DEPTH       = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  deq_pkg::t_dp_cmd                    i_cmd,
    output deq_pkg::t_dp_status                 o_status_ctl,
    input  logic        [deq_pkg::OP_W-1:0]     i_operation,
    input  logic        [deq_pkg::VAL_W-1:0]    i_item_value,
    input  logic signed [deq_pkg::POS_W-1:0]    i_position,
    input  logic signed [deq_pkg::POS_W-1:0]    i_range_stop,
    output logic                                o_strobe,
    output logic        [deq_pkg::VAL_W-1:0]    o_result_value,
    output logic        [deq_pkg::STAT_W-1:0]   o_status,
    output logic        [deq_pkg::CNT_W-1:0]    o_stored_count,
    output logic        [deq_pkg::CNT_W-1:0]    o_range_count,
    output logic                                o_last
);
    import deq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);
    localparam int SW = (VALUE_WIDTH < VAL_W) ? VALUE_WIDTH : VAL_W;

    function automatic logic [AW-1:0] ring(input logic [AW-1:0] base,
                                           input logic [AW-1:0] off);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (AW+1)'(DEPTH)) begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    logic [SW-1:0] r_mem [DEPTH];

    logic        [OP_W-1:0]   r_op;
    logic        [SW-1:0]     r_val;
    logic signed [POS_W-1:0]  r_pos;
    logic signed [POS_W-1:0]  r_stop;
    logic        [AW-1:0]     r_front;
    logic        [NW-1:0]     r_count;
    logic        [AW-1:0]     r_addr;
    logic        [NW-1:0]     r_left;
    logic        [NW-1:0]     r_rcnt;
    logic                     r_strobe;
    logic                     r_last;
    logic        [STAT_W-1:0] r_status;
    logic        [SW-1:0]     r_data;

    logic signed [8:0] w_n;
    logic signed [8:0] w_p;
    logic signed [8:0] w_e0;
    logic signed [8:0] w_s;
    logic signed [8:0] w_e;
    logic signed [8:0] w_cnt9;
    logic              w_idx_ok;
    logic              w_rng_ok;
    logic              w_full;
    logic              w_empty;
    logic [NW-1:0]     w_cnt_m1;
    logic [AW-1:0]     w_front_dec;
    logic [AW-1:0]     w_front_inc;
    logic [AW-1:0]     w_addr_inc;
    logic [AW-1:0]     w_off;
    logic [AW-1:0]     w_ring;
    logic [AW-1:0]     w_wr_addr;
    logic [AW-1:0]     w_rd_addr;
    logic [STAT_W-1:0] w_status;
    logic              w_rd_dec;
    logic              w_wr_dec;
    logic              w_range_go;
    logic [AW-1:0]     w_front_nxt;
    logic [NW-1:0]     w_count_nxt;
    logic              w_rd_en;
    logic              w_wr_en;

    // position arithmetic on 9-bit signed values
    assign w_n      = $signed(9'(r_count));
    assign w_p      = r_pos[POS_W-1] ? ({r_pos[POS_W-1], r_pos} + w_n)
                                     : {r_pos[POS_W-1], r_pos};
    assign w_e0     = r_stop[POS_W-1] ? ({r_stop[POS_W-1], r_stop} + w_n)
                                      : {r_stop[POS_W-1], r_stop};
    assign w_s      = w_p[8] ? 9'sd0 : w_p;
    assign w_e      = (w_e0 >= w_n) ? (w_n - 9'sd1) : w_e0;
    assign w_cnt9   = w_e - w_s + 9'sd1;
    assign w_idx_ok = !w_p[8] && (w_p < w_n);
    assign w_rng_ok = (w_n != 9'sd0) && !(w_s > w_e) && (w_s < w_n);

    assign w_full      = (r_count == NW'(DEPTH));
    assign w_empty     = (r_count == '0);
    assign w_cnt_m1    = r_count - NW'(1);
    assign w_front_dec = (r_front == '0) ? AW'(DEPTH - 1) : (r_front - AW'(1));
    assign w_front_inc = ring(r_front, AW'(1));
    assign w_addr_inc  = (r_addr == AW'(DEPTH - 1)) ? '0 : (r_addr + AW'(1));
    assign w_ring      = ring(r_front, w_off);
    // push front writes below the front entry, everything else at the ring offset
    assign w_wr_addr   = (r_op == OP_PUSH_FRONT) ? w_front_dec : w_ring;

    always_comb begin
        w_off       = '0;
        w_status    = ST_EMPTY;
        w_rd_dec    = 1'b0;
        w_wr_dec    = 1'b0;
        w_range_go  = 1'b0;
        w_front_nxt = r_front;
        w_count_nxt = r_count;
        unique case (r_op)
            OP_PUSH_FRONT: begin
                w_status  = w_full ? ST_FULL : ST_OK;
                w_wr_dec  = !w_full;
                if (!w_full) begin
                    w_front_nxt = w_front_dec;
                    w_count_nxt = r_count + NW'(1);
                end
            end
            OP_PUSH_BACK: begin
                w_off    = r_count[AW-1:0];
                w_status = w_full ? ST_FULL : ST_OK;
                w_wr_dec = !w_full;
                if (!w_full) begin
                    w_count_nxt = r_count + NW'(1);
                end
            end
            OP_POP_FRONT: begin
                w_status = w_empty ? ST_EMPTY : ST_OK;
                w_rd_dec = !w_empty;
                if (!w_empty) begin
                    w_front_nxt = w_front_inc;
                    w_count_nxt = w_cnt_m1;
                end
            end
            OP_POP_BACK: begin
                w_off    = w_cnt_m1[AW-1:0];
                w_status = w_empty ? ST_EMPTY : ST_OK;
                w_rd_dec = !w_empty;
                if (!w_empty) begin
                    w_count_nxt = w_cnt_m1;
                end
            end
            OP_INDEX: begin
                w_off    = w_p[AW-1:0];
                w_status = w_idx_ok ? ST_OK : ST_EMPTY;
                w_rd_dec = w_idx_ok;
            end
            OP_RANGE: begin
                w_off      = w_s[AW-1:0];
                w_status   = w_rng_ok ? ST_OK : ST_EMPTY;
                w_range_go = w_rng_ok;
            end
            default: begin
                w_status = ST_EMPTY;
            end
        endcase
    end

    assign w_rd_en   = (i_cmd.exec && w_rd_dec) || i_cmd.range_step;
    assign w_wr_en   = i_cmd.exec && w_wr_dec;
    assign w_rd_addr = i_cmd.range_step ? r_addr : w_ring;

    // ring memory, registered read
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= r_val;
        end
        if (w_rd_en) begin
            r_data <= r_mem[w_rd_addr];
        end else if (i_cmd.exec) begin
            r_data <= '0;
        end
    end

    // operand capture and payload of the result
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_operation;
            r_val  <= i_item_value[SW-1:0];
            r_pos  <= i_position;
            r_stop <= i_range_stop;
        end
        if (i_cmd.exec) begin
            r_status <= w_status;
            r_last   <= 1'b1;
            r_rcnt   <= '0;
            if (w_range_go) begin
                r_addr <= w_ring;
                r_left <= w_cnt9[NW-1:0];
                r_rcnt <= w_cnt9[NW-1:0];
            end
        end
        if (i_cmd.range_step) begin
            r_status <= ST_OK;
            r_last   <= (r_left == NW'(1));
            r_addr   <= w_addr_inc;
            r_left   <= r_left - NW'(1);
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front  <= '0;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= (i_cmd.exec && !w_range_go) || i_cmd.range_step;
            if (i_cmd.exec) begin
                r_front <= w_front_nxt;
                r_count <= w_count_nxt;
            end
        end
    end

    assign o_status_ctl.range_go   = w_range_go;
    assign o_status_ctl.range_done = (r_left == NW'(1));

    assign o_strobe       = r_strobe;
    assign o_result_value = VAL_W'(r_data);
    assign o_status       = r_status;
    assign o_stored_count = CNT_W'(r_count);
    assign o_range_count  = CNT_W'(r_rcnt);
    assign o_last         = r_last;

endmodule

### rtl/core/deq_checker.sv
// port-level checks for the double-ended queue, bound to the top level
`include "assert_macros.svh"

module deq_checker #(
    parameter int DEPTH = 64
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          o_strobe,
    input logic [deq_pkg::STAT_W-1:0]    o_status,
    input logic [deq_pkg::CNT_W-1:0]     o_stored_count,
    input logic [deq_pkg::CNT_W-1:0]     o_range_count,
    input logic                          o_last
);
    import deq_pkg::*;

    // an accepted command keeps the block busy in the next cycle
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)

    // range beats come back to back until the last one
    `ASSERT_NEXT(a_range_burst, i_clk, i_rst_n, o_strobe && !o_last, o_strobe)

    // an error beat is always single and carries no range count
    `ASSERT_IMPLY(a_err_single, i_clk, i_rst_n, o_strobe && (o_status != ST_OK), o_last && (o_range_count == '0))

    // a dropped push only happens on a full queue
    `ASSERT_IMPLY(a_full_count, i_clk, i_rst_n, o_strobe && (o_status == ST_FULL), o_stored_count == CNT_W'(DEPTH))

    // the fill level never passes the depth
    `ASSERT_IMPLY(a_count_max, i_clk, i_rst_n, o_strobe, o_stored_count <= CNT_W'(DEPTH))

endmodule

bind double_ended_queue deq_checker #(
    .DEPTH (DEPTH)
) u_deq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_strobe       (o_strobe),
    .o_status       (o_status),
    .o_stored_count (o_stored_count),
    .o_range_count  (o_range_count),
    .o_last         (o_last)
);
